// ===== rtl/core/ostt_pkg.sv =====
// Shared types and constants for the one-shot token table.
package ostt_pkg;

  localparam int unsigned TokenW = 160;
  localparam int unsigned HeldW  = 9;

  localparam logic ReqInsert  = 1'b0;
  localparam logic ReqConsume = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] token_high;
    logic [63:0] token_mid;
    logic [31:0] token_low;
  } req_t;

  typedef struct packed {
    logic             match_found;
    logic             oldest_evicted;
    logic [HeldW-1:0] entries_held;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StFin
  } state_e;

endpackage

// ===== rtl/core/ostt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ostt_ram #(
  parameter int unsigned Width = 160,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/ostt_ctrl.sv =====
// Request sequencer: ring pointers, scan, gap close and result build.
module ostt_ctrl #(
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  ostt_pkg::req_t                in_req_i,
  output logic                          in_stall_o,
  output logic                          ram_we_o,
  output logic [AddrW-1:0]              ram_waddr_o,
  output logic [ostt_pkg::TokenW-1:0]   ram_wdata_o,
  output logic                          ram_re_o,
  output logic [AddrW-1:0]              ram_raddr_o,
  input  logic [ostt_pkg::TokenW-1:0]   ram_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ostt_pkg::rsp_t                res_o
);

  ostt_pkg::state_e state_q, state_d;
  logic [AddrW-1:0]            head_q, head_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [CntW-1:0]             idx_q, idx_d;
  logic [ostt_pkg::TokenW-1:0] tok_q, tok_d;
  ostt_pkg::rsp_t              res_q, res_d;

  logic [CntW:0]               cnt_x, idx_p1, idx_p2;
  logic [ostt_pkg::TokenW-1:0] in_tok;

  // logical position -> physical slot, oldest entry sits at head_q
  function automatic logic [AddrW-1:0] phys(input logic [AddrW-1:0] head,
                                            input logic [CntW:0] pos);
    logic [AddrW+1:0] s;
    s = (AddrW + 2)'(head) + (AddrW + 2)'(pos);
    if (s >= (AddrW + 2)'(Depth)) begin
      s = s - (AddrW + 2)'(Depth);
    end
    return s[AddrW-1:0];
  endfunction

  // count reported modulo 512
  function automatic logic [ostt_pkg::HeldW-1:0] held(input logic [CntW-1:0] c);
    logic [CntW+ostt_pkg::HeldW-1:0] w;
    w = (CntW + ostt_pkg::HeldW)'(c);
    return w[ostt_pkg::HeldW-1:0];
  endfunction

  assign cnt_x  = (CntW + 1)'(cnt_q);
  assign idx_p1 = (CntW + 1)'(idx_q) + (CntW + 1)'(1);
  assign idx_p2 = (CntW + 1)'(idx_q) + (CntW + 1)'(2);
  assign in_tok = {in_req_i.token_high, in_req_i.token_mid, in_req_i.token_low};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ostt_pkg::StIdle;
      head_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    tok_d       = tok_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = phys(head_q, cnt_x);
    ram_wdata_o = in_tok;
    ram_re_o    = 1'b0;
    ram_raddr_o = phys(head_q, '0);
    in_stall_o  = (state_q != ostt_pkg::StIdle);
    res_valid_o = (state_q == ostt_pkg::StFin);

    case (state_q)
      ostt_pkg::StIdle: begin
        if (in_valid_i) begin
          res_d.match_found    = 1'b0;
          res_d.oldest_evicted = 1'b0;
          if (in_req_i.req_type == ostt_pkg::ReqInsert) begin
            // full: new token lands in the oldest slot, head moves on
            ram_we_o = 1'b1;
            if (cnt_x == (CntW + 1)'(Depth)) begin
              head_d               = phys(head_q, (CntW + 1)'(1));
              res_d.oldest_evicted = 1'b1;
              res_d.entries_held   = held(cnt_q);
            end else begin
              cnt_d              = cnt_q + CntW'(1);
              res_d.entries_held = held(cnt_q + CntW'(1));
            end
            state_d = ostt_pkg::StFin;
          end else begin
            tok_d              = in_tok;
            idx_d              = '0;
            res_d.entries_held = held(cnt_q);
            if (cnt_q == '0) begin
              state_d = ostt_pkg::StFin;
            end else begin
              ram_re_o = 1'b1;
              state_d  = ostt_pkg::StScan;
            end
          end
        end
      end
      ostt_pkg::StScan: begin
        // read data holds entry idx_q; next entry is fetched meanwhile
        ram_re_o    = (idx_p1 < cnt_x);
        ram_raddr_o = phys(head_q, idx_p1);
        if (ram_rdata_i == tok_q) begin
          state_d = ostt_pkg::StShift;
        end else if (idx_p1 < cnt_x) begin
          idx_d = idx_p1[CntW-1:0];
        end else begin
          state_d = ostt_pkg::StFin;
        end
      end
      ostt_pkg::StShift: begin
        // read data holds entry idx_q+1, written back one place older
        ram_re_o    = (idx_p2 < cnt_x);
        ram_raddr_o = phys(head_q, idx_p2);
        if (idx_p1 < cnt_x) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = phys(head_q, (CntW + 1)'(idx_q));
          ram_wdata_o = ram_rdata_i;
          idx_d       = idx_p1[CntW-1:0];
        end else begin
          cnt_d              = cnt_q - CntW'(1);
          res_d.match_found  = 1'b1;
          res_d.entries_held = held(cnt_q - CntW'(1));
          state_d            = ostt_pkg::StFin;
        end
      end
      ostt_pkg::StFin: begin
        if (res_ready_i) begin
          state_d = ostt_pkg::StIdle;
        end
      end
      default: begin
        state_d = ostt_pkg::StIdle;
      end
    endcase
  end

  assign res_o = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= (CntW + 1)'(Depth))
    else $error("held count above table depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AddrW + 1)'(head_q) < (AddrW + 1)'(Depth))
    else $error("head pointer out of range");

  a_busy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we_o && state_q != ostt_pkg::StIdle) |-> state_q == ostt_pkg::StShift)
    else $error("table write outside insert or gap close");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ostt_pkg::StScan || state_q == ostt_pkg::StShift) |-> cnt_q != '0)
    else $error("scan on empty table");

endmodule

// ===== rtl/core/one_shot_token_table_top.sv =====
// Top level of the one-shot token table: table RAM, sequencer, result register.
//
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per item.
//   req_type 0 appends the token at the newest end; on a full table the
//   oldest token is dropped first. req_type 1 looks for the oldest equal
//   token, removes it and closes the gap so the order is kept.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): exactly one result
//   item per request: match flag, eviction flag, tokens held afterwards
//   (reported modulo 512).
// Tokens live in a ring buffer in one 160-bit RAM with registered read; the
//   oldest entry sits at a head pointer, so eviction only moves the pointer.
// Sequence: an insert writes the RAM and goes straight to its result. A consume walks
//   the RAM one entry per cycle: a match at position k scans k+1 entries and
//   then moves the count-k-1 younger entries; with no match it scans every
//   held entry. The single RAM port pair sets that pace.
// One request is in work at a time; in_stall_o is high while it runs.
// The result register lets a new request start while an earlier result is
//   still stalled; a finished result then waits until the register frees.
// Reset empties the table at once (count and head cleared); RAM slots at or
//   above the count are never read, so no clearing pass is needed.
module one_shot_token_table_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ostt_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ostt_pkg::rsp_t out_rsp_o
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                        ram_we, ram_re;
  logic [AddrW-1:0]            ram_waddr, ram_raddr;
  logic [ostt_pkg::TokenW-1:0] ram_wdata, ram_rdata;

  logic           res_valid, res_ready;
  ostt_pkg::rsp_t res;

  logic           out_valid_q, out_valid_d;
  ostt_pkg::rsp_t out_q;

  ostt_ram #(
    .Width (ostt_pkg::TokenW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ostt_ctrl #(
    .Depth (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result register frees when empty or being taken this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
